### hw/rtl/rdq_pkg.sv
// ----------------------------------------------------------------------------
// rdq_pkg
// Shared types and codes of the random drop and delay queue.
// ----------------------------------------------------------------------------
package rdq_pkg;

    localparam int DUE_W   = 32;
    localparam int TAG_W   = 16;
    localparam int RANK_W  = 7;
    localparam int DRAW_W  = 20;
    localparam int CFG_W   = 20;
    localparam int CNT_W   = 32;
    localparam int FSET_W  = 64;
    localparam int CIDX_W  = 8;
    localparam int KIND_W  = 3;
    localparam int OP_W    = 2;
    localparam int PROD_W  = 2 * DRAW_W;
    localparam int QUO_W   = 21;
    localparam int REM_W   = 20;
    localparam logic [REM_W:0] MILLION = 21'd1000000;

    localparam logic [CFG_W-1:0] DROP_THR_RESET  = 20'd10000;
    localparam logic [CFG_W-1:0] MAX_DELAY_RESET = 20'd2000;

    localparam logic [CIDX_W-1:0] REG_DROP_THR  = 8'd0;
    localparam logic [CIDX_W-1:0] REG_MAX_DELAY = 8'd1;

    localparam logic [OP_W-1:0] OP_ARRIVE = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
    localparam logic [OP_W-1:0] OP_FAIL   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_QUEUED    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DROPPED   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DELIVERED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DISCARDED = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DONE      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW  = 3'd5;

    typedef struct packed {
        logic              valid;
        logic [DUE_W-1:0]  due;
        logic [TAG_W-1:0]  tag;
        logic [RANK_W-1:0] rank;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } cell_cmd_t;

endpackage

### hw/rtl/rdq_cell.sv
// ----------------------------------------------------------------------------
// rdq_cell
// One slot of the sorted queue; takes the new entry, its left or right
// neighbour, or holds.
// ----------------------------------------------------------------------------
module rdq_cell
    import rdq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    input  entry_t    new_entry,
    input  entry_t    prev_entry,
    input  logic      prev_gt,
    input  entry_t    next_entry,
    output entry_t    cur,
    output logic      gt
);

    logic   valid_reg;
    logic   valid_next;
    entry_t data_reg;
    entry_t data_next;

    // later than the new entry, or empty: the new entry goes at or before here
    assign gt = !valid_reg || (data_reg.due > new_entry.due);

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (cmd.shift)
        begin
            data_next  = next_entry;
            valid_next = next_entry.valid;
        end
        else if (cmd.insert && gt)
        begin
            data_next  = prev_gt ? prev_entry : new_entry;
            valid_next = prev_gt ? prev_entry.valid : 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        cur       = data_reg;
        cur.valid = valid_reg;
    end

endmodule

### hw/rtl/rdq_delay_unit.sv
// ----------------------------------------------------------------------------
// rdq_delay_unit
// Delay = floor(draw * max_delay / 1e6): a registered multiply, a reciprocal
// estimate of the quotient, a registered remainder and a final correction.
// ----------------------------------------------------------------------------
module rdq_delay_unit
    import rdq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DRAW_W-1:0] draw,
    input  logic [CFG_W-1:0]  max_delay,
    output logic              done,
    output logic [QUO_W-1:0]  delay
);

    // floor(p / 1e6) = floor((p >> 6) / 15625); estimate it from p >> 19
    localparam int RCP_W = 20;
    localparam int EST_W = QUO_W + RCP_W;
    localparam int RES_W = 22;
    localparam logic [RCP_W-1:0] RECIP   = 20'd549755;   // floor(2^33 / 15625)
    localparam logic [RES_W-1:0] ONE_M   = 22'd1000000;
    localparam logic [RES_W-1:0] TWO_M   = 22'd2000000;
    localparam logic [RES_W-1:0] THREE_M = 22'd3000000;

    logic              mul_reg;
    logic              est_vld_reg;
    logic              rem_vld_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [QUO_W-1:0]  est_reg;
    logic [RES_W-1:0]  rem_reg;
    logic [EST_W-1:0]  est_full;
    logic [PROD_W-1:0] est_back;
    logic [1:0]        fix;

    assign est_full = EST_W'(prod_reg[PROD_W-1:PROD_W-QUO_W]) * EST_W'(RECIP);
    assign est_back = PROD_W'(est_reg) * PROD_W'(MILLION);

    // the estimate never exceeds the quotient and falls short by at most three
    always_comb
    begin
        if (rem_reg >= THREE_M)
            fix = 2'd3;
        else if (rem_reg >= TWO_M)
            fix = 2'd2;
        else if (rem_reg >= ONE_M)
            fix = 2'd1;
        else
            fix = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg     <= 1'b0;
            est_vld_reg <= 1'b0;
            rem_vld_reg <= 1'b0;
        end
        else
        begin
            mul_reg     <= start;
            est_vld_reg <= mul_reg;
            rem_vld_reg <= est_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            prod_reg <= PROD_W'(draw) * PROD_W'(max_delay);
        if (mul_reg)
            est_reg <= est_full[EST_W-1:RCP_W];
        if (est_vld_reg)
            rem_reg <= RES_W'(prod_reg - est_back);
    end

    assign done  = rem_vld_reg;
    assign delay = est_reg + QUO_W'(fix);

endmodule

### hw/rtl/random_drop_delay_queue_unit.sv
// ----------------------------------------------------------------------------
// random_drop_delay_queue_unit
// Random drop and delay emulator over a sorted chain of queue cells.
// ----------------------------------------------------------------------------
// A drop, overflow or fail update gives its beat in the cycle after accept.
// A queued arrival goes through multiply, reciprocal estimate, remainder,
// correction, then insert.
// A tick releases one due entry a cycle from the head cell while the output
// is not blocked, then a done beat. One item at a time, plus output back-pressure.
// Reset (rst_n, async low) empties the chain, zeroes counters and failed set
// and restores register defaults.
module random_drop_delay_queue_unit
    import rdq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32,
    parameter int MAX_MEMBERS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // [15:0] message_tag, [22:16] origin_rank, [42:23] random_draw,
    // [74:43] now_us, [138:75] failed_set, [143:139] zero
    input  logic [143:0]       s_axis_tdata,
    // [1:0] op
    input  logic [OP_W-1:0]    s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [15:0] tag_out, [22:16] rank_out, [54:23] delivered_count,
    // [86:55] dropped_count, [87] zero
    output logic [87:0]        m_axis_tdata,
    // [2:0] kind
    output logic [KIND_W-1:0]  m_axis_tuser,
    output logic               m_axis_tlast,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CALC = 4'b0010,
        ST_INS  = 4'b0100,
        ST_TICK = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   drop_thr_reg, max_delay_reg;
    logic [FSET_W-1:0]  failed_reg, failed_next;
    logic [CNT_W-1:0]   deliv_reg, deliv_next;
    logic [CNT_W-1:0]   dropc_reg, dropc_next;
    logic [TAG_W-1:0]   tag_reg;
    logic [RANK_W-1:0]  rank_reg;
    logic [DRAW_W-1:0]  draw_reg;
    logic [DUE_W-1:0]   now_reg;
    logic [QUO_W-1:0]   delay_reg;

    logic               out_valid_reg;
    logic [KIND_W-1:0]  out_kind_reg;
    logic [TAG_W-1:0]   out_tag_reg;
    logic [RANK_W-1:0]  out_rank_reg;
    logic               out_last_reg;
    logic [CNT_W-1:0]   out_deliv_reg, out_dropc_reg;

    logic               can_emit, accept, emit, emit_last;
    logic [KIND_W-1:0]  emit_kind;
    logic [TAG_W-1:0]   emit_tag;
    logic [RANK_W-1:0]  emit_rank;
    logic               calc_start, calc_done;
    logic [QUO_W-1:0]   calc_delay;
    logic [OP_W-1:0]    in_op;
    logic [TAG_W-1:0]   in_tag;
    logic [RANK_W-1:0]  in_rank;
    logic [DRAW_W-1:0]  in_draw;
    logic [DUE_W-1:0]   in_now;
    logic [FSET_W-1:0]  in_fset;
    logic               full, head_due, head_failed;
    cell_cmd_t          cmd;
    entry_t             new_entry;
    entry_t             cells [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] gts;

    assign in_op   = s_axis_tuser;
    assign in_tag  = s_axis_tdata[15:0];
    assign in_rank = s_axis_tdata[22:16];
    assign in_draw = s_axis_tdata[42:23];
    assign in_now  = s_axis_tdata[74:43];
    assign in_fset = s_axis_tdata[138:75];

    assign cfg_ready     = 1'b1;
    assign can_emit      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && can_emit;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign full     = cells[QUEUE_DEPTH-1].valid;
    assign head_due = cells[0].valid && (cells[0].due <= now_reg);
    assign head_failed = !cells[0].rank[RANK_W-1]
                         && ({1'b0, cells[0].rank[5:0]} < RANK_W'(MAX_MEMBERS))
                         && failed_reg[cells[0].rank[5:0]];

    always_comb
    begin
        new_entry.valid = 1'b1;
        new_entry.due   = now_reg + DUE_W'(delay_reg);
        new_entry.tag   = tag_reg;
        new_entry.rank  = rank_reg;
    end

    always_comb
    begin
        state_next  = state_reg;
        failed_next = failed_reg;
        deliv_next  = deliv_reg;
        dropc_next  = dropc_reg;
        emit        = 1'b0;
        emit_last   = 1'b1;
        emit_kind   = KIND_DONE;
        emit_tag    = '0;
        emit_rank   = '0;
        calc_start  = 1'b0;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        OP_ARRIVE:
                        begin
                            if (in_draw < drop_thr_reg || full)
                            begin
                                emit       = 1'b1;
                                emit_kind  = full && !(in_draw < drop_thr_reg)
                                             ? KIND_OVERFLOW : KIND_DROPPED;
                                emit_tag   = in_tag;
                                emit_rank  = in_rank;
                                dropc_next = dropc_reg + 32'd1;
                            end
                            else
                            begin
                                calc_start = 1'b1;
                                state_next = ST_CALC;
                            end
                        end
                        OP_TICK:
                            state_next = ST_TICK;
                        OP_FAIL:
                        begin
                            failed_next = in_fset;
                            emit        = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CALC:
            begin
                if (calc_done)
                    state_next = ST_INS;
            end
            ST_INS:
            begin
                if (can_emit)
                begin
                    cmd.insert = 1'b1;
                    emit       = 1'b1;
                    emit_kind  = KIND_QUEUED;
                    emit_tag   = tag_reg;
                    emit_rank  = rank_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                if (can_emit)
                begin
                    emit = 1'b1;
                    if (head_due)
                    begin
                        // release the head and advance the chain
                        cmd.shift  = 1'b1;
                        emit_last  = 1'b0;
                        emit_kind  = head_failed ? KIND_DISCARDED : KIND_DELIVERED;
                        emit_tag   = cells[0].tag;
                        emit_rank  = cells[0].rank;
                        deliv_next = deliv_reg + 32'd1;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    rdq_delay_unit u_delay (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (calc_start),
        .draw      (in_draw),
        .max_delay (max_delay_reg),
        .done      (calc_done),
        .delay     (calc_delay)
    );

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            entry_t prev_e, next_e;
            logic   prev_g;
            if (gi == 0)
            begin : g_head
                assign prev_e = new_entry;
                assign prev_g = 1'b1;
            end
            else
            begin : g_body
                assign prev_e = cells[gi-1];
                assign prev_g = gts[gi-1];
            end
            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign next_e = '0;
            end
            else
            begin : g_mid
                assign next_e = cells[gi+1];
            end
            rdq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .new_entry  (new_entry),
                .prev_entry (prev_e),
                .prev_gt    (prev_g),
                .next_entry (next_e),
                .cur        (cells[gi]),
                .gt         (gts[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            drop_thr_reg  <= DROP_THR_RESET;
            max_delay_reg <= MAX_DELAY_RESET;
            failed_reg    <= '0;
            deliv_reg     <= '0;
            dropc_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            failed_reg <= failed_next;
            deliv_reg  <= deliv_next;
            dropc_reg  <= dropc_next;
            if (cfg_valid && cfg_index == REG_DROP_THR)
                drop_thr_reg <= cfg_data;
            if (cfg_valid && cfg_index == REG_MAX_DELAY)
                max_delay_reg <= cfg_data;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tag_reg  <= in_tag;
            rank_reg <= in_rank;
            draw_reg <= in_draw;
            now_reg  <= in_now;
        end
        if (calc_done)
            delay_reg <= calc_delay;
        if (emit)
        begin
            out_kind_reg  <= emit_kind;
            out_tag_reg   <= emit_tag;
            out_rank_reg  <= emit_rank;
            out_last_reg  <= emit_last;
            out_deliv_reg <= deliv_next;
            out_dropc_reg <= dropc_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {1'b0, out_dropc_reg, out_deliv_reg, out_rank_reg, out_tag_reg};

    // chain checks: valid cells form a prefix and are in due order
    logic chain_ok;
    always_comb
    begin
        chain_ok = 1'b1;
        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
        begin
            if (!cells[i].valid && cells[i+1].valid)
                chain_ok = 1'b0;
            if (cells[i].valid && cells[i+1].valid && cells[i].due > cells[i+1].due)
                chain_ok = 1'b0;
        end
    end

    a_chain_ok: assert property (@(posedge clk) disable iff (!rst_n) chain_ok)
        else $error("queue chain out of order");

    a_release_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |->
            (m_axis_tuser == KIND_DELIVERED || m_axis_tuser == KIND_DISCARDED))
        else $error("non-final beat is not a release");

    a_draw_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CALC |=> $stable(draw_reg) || state_reg == ST_INS)
        else $error("draw changed during delay calculation");

    a_no_emit_stall: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> can_emit)
        else $error("beat produced while output register blocked");

endmodule

### tb/rdq_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rdq_checker
// Watches the input, output and register channels of the drop and delay
// queue, predicts every result beat and compares it field by field.
// ----------------------------------------------------------------------------
module rdq_checker
    import rdq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [143:0]        s_axis_tdata,
    input  logic [OP_W-1:0]     s_axis_tuser,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [87:0]         m_axis_tdata,
    input  logic [KIND_W-1:0]   m_axis_tuser,
    input  logic                m_axis_tlast,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    output int                  fail_count,
    output int                  pending
);

    localparam int DEPTH = 32;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
        logic [RANK_W-1:0] rank;
        logic              last;
        logic [CNT_W-1:0]  delivered;
        logic [CNT_W-1:0]  dropped;
    } beat_t;

    beat_t             want_q[$];
    logic [CFG_W-1:0]  thr;
    logic [CFG_W-1:0]  max_delay;
    logic [DUE_W-1:0]  slot_due [DEPTH];
    logic [TAG_W-1:0]  slot_tag [DEPTH];
    logic [RANK_W-1:0] slot_rank[DEPTH];
    logic              slot_used[DEPTH];
    int unsigned       slot_order[DEPTH];
    int unsigned       arrivals;
    logic [FSET_W-1:0] failed;
    logic [CNT_W-1:0]  delivered_total;
    logic [CNT_W-1:0]  dropped_total;

    assign pending = want_q.size();

    function automatic logic origin_failed(logic [RANK_W-1:0] r);
        if (r[RANK_W-1])
            return 1'b0;
        return failed[r[5:0]];
    endfunction

    task automatic push(logic [KIND_W-1:0] k, logic [TAG_W-1:0] t,
                        logic [RANK_W-1:0] r, logic l);
        beat_t b;
        b.kind = k;
        b.tag = t;
        b.rank = r;
        b.last = l;
        b.delivered = delivered_total;
        b.dropped = dropped_total;
        want_q.push_back(b);
    endtask

    task automatic predict_item(logic [OP_W-1:0] op, logic [143:0] d);
        logic [TAG_W-1:0]  tag;
        logic [RANK_W-1:0] rank;
        logic [DRAW_W-1:0] draw;
        logic [DUE_W-1:0]  now;
        logic [63:0]       delay;
        int                slot;
        int                best;
        tag  = d[15:0];
        rank = d[22:16];
        draw = d[42:23];
        now  = d[74:43];
        slot = -1;
        if (op == OP_ARRIVE) begin
            if (draw < thr) begin
                dropped_total++;
                push(KIND_DROPPED, tag, rank, 1'b1);
                return;
            end
            for (int i = DEPTH - 1; i >= 0; i--)
                if (!slot_used[i])
                    slot = i;
            if (slot < 0) begin
                dropped_total++;
                push(KIND_OVERFLOW, tag, rank, 1'b1);
                return;
            end
            delay = (64'(draw) * 64'(max_delay)) / 64'd1000000;
            slot_due[slot]   = now + delay[31:0];
            slot_tag[slot]   = tag;
            slot_rank[slot]  = rank;
            slot_order[slot] = arrivals++;
            slot_used[slot]  = 1'b1;
            push(KIND_QUEUED, tag, rank, 1'b1);
        end else if (op == OP_TICK) begin
            forever begin
                best = -1;
                for (int i = 0; i < DEPTH; i++)
                    if (slot_used[i] && slot_due[i] <= now && (best < 0
                        || slot_due[i] < slot_due[best]
                        || (slot_due[i] == slot_due[best]
                            && slot_order[i] < slot_order[best])))
                        best = i;
                if (best < 0)
                    break;
                slot_used[best] = 1'b0;
                delivered_total++;
                push(origin_failed(slot_rank[best]) ? KIND_DISCARDED : KIND_DELIVERED,
                     slot_tag[best], slot_rank[best], 1'b0);
            end
            push(KIND_DONE, '0, '0, 1'b1);
        end else if (op == OP_FAIL) begin
            failed = d[138:75];
            push(KIND_DONE, '0, '0, 1'b1);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        beat_t got;
        beat_t want;
        if (!rst_n) begin
            want_q.delete();
            thr = DROP_THR_RESET;
            max_delay = MAX_DELAY_RESET;
            for (int i = 0; i < DEPTH; i++)
                slot_used[i] = 1'b0;
            arrivals = 0;
            failed = '0;
            delivered_total = '0;
            dropped_total = '0;
            fail_count = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind = m_axis_tuser;
                got.tag = m_axis_tdata[15:0];
                got.rank = m_axis_tdata[22:16];
                got.last = m_axis_tlast;
                got.delivered = m_axis_tdata[54:23];
                got.dropped = m_axis_tdata[86:55];
                if (want_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected beat %h", $time, got);
                end else begin
                    want = want_q.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        $display("%0t: beat mismatch expected %h actual %h",
                                 $time, want, got);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_DROP_THR)
                    thr = cfg_data;
                else if (cfg_index == REG_MAX_DELAY)
                    max_delay = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_item(s_axis_tuser, s_axis_tdata);
        end
    end

endmodule

### tb/tb_random_drop_delay_queue_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_random_drop_delay_queue_unit
// Drives arrivals, ticks and fail updates in random bursts through several
// register settings; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_random_drop_delay_queue_unit;
    import rdq_pkg::*;

    localparam int LIMIT = 400000;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [143:0]       s_axis_tdata;
    logic [OP_W-1:0]    s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [87:0]        m_axis_tdata;
    logic [KIND_W-1:0]  m_axis_tuser;
    logic               m_axis_tlast;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CIDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    int                 fail_count;
    int                 pending;
    int                 cycles;
    int                 hold_off;
    logic [31:0]        now;
    logic [15:0]        tag_seq;

    random_drop_delay_queue_unit uut (.*);

    rdq_checker chk (.*);

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: own stall pattern, plus long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else
            m_axis_tready <= (cycles % 64 < 20) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    // hold valid after the beat; gap and wait_idle drop it
    task automatic send(logic [OP_W-1:0] op, logic [15:0] tag, logic [6:0] rank,
                        logic [19:0] draw, logic [31:0] t, logic [63:0] fset);
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'b0, fset, t, draw, rank, tag};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic gap();
        if ($urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_item();
        int          sel;
        logic [6:0]  rank;
        logic [19:0] draw;
        sel  = $urandom_range(0, 99);
        rank = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 63));
        draw = ($urandom_range(0, 9) == 0) ? 20'($urandom_range(999000, 1048575))
                                           : 20'($urandom_range(0, 999999));
        if (sel < 60)
            send(OP_ARRIVE, 16'($urandom), rank, draw, now, 64'($urandom));
        else if (sel < 85)
        begin
            now = now + $urandom_range(0, 3000);
            send(OP_TICK, 16'($urandom), rank, draw, now, {$urandom, $urandom});
        end
        else if (sel < 95)
            send(OP_FAIL, 16'($urandom), rank, draw, now, {$urandom, $urandom});
        else if (sel < 98)
            send(2'd3, 16'($urandom), rank, draw, now, {$urandom, $urandom});
        else
        begin
            now = now + 32'($urandom);
            send(OP_TICK, 16'($urandom), rank, draw, now, 64'd0);
        end
        gap();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cycles = 0;
        hold_off = 0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_ARRIVE;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_DROP_THR;
        cfg_data = '0;
        now = 32'd100;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset settings, extremes and special cases
        send(OP_ARRIVE, 16'h0000, 7'd0, 20'd0, now, '0);
        send(OP_ARRIVE, 16'hffff, 7'h40, 20'd999999, now, '0);
        send(OP_ARRIVE, 16'h1234, 7'h7f, 20'd10000, 32'hffff_fff0, '0);
        send(OP_ARRIVE, 16'h5555, 7'd63, 20'hfffff, now, '0);
        send(OP_FAIL, '0, '0, '0, now, {64{1'b1}});
        send(OP_TICK, '0, '0, '0, now + 32'd2000, '0);
        send(OP_FAIL, '0, '0, '0, now, 64'h8000_0000_0000_0001);
        send(2'd3, 16'hbeef, 7'd1, 20'd500000, now, '0);
        send(OP_TICK, '0, '0, '0, 32'hffff_ffff, '0);
        wait_idle();
        write_reg(REG_DROP_THR, 20'd0);
        write_reg(REG_MAX_DELAY, 20'd0);
        write_reg(8'd7, 20'hfffff);
        // fill past depth for overflow, equal due times keep arrival order
        for (int i = 0; i < 34; i++)
            send(OP_ARRIVE, 16'(i), 7'(i), 20'($urandom_range(0, 999999)), now, '0);
        send(OP_TICK, '0, '0, '0, now, '0);
        wait_idle();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin write_reg(REG_DROP_THR, 20'd1000000);
                         write_reg(REG_MAX_DELAY, 20'd1000000); end
                1: begin write_reg(REG_DROP_THR, 20'd100000);
                         write_reg(REG_MAX_DELAY, 20'd5000); end
                2: begin write_reg(REG_DROP_THR, 20'hfffff);
                         write_reg(REG_MAX_DELAY, 20'hfffff); end
                default: begin write_reg(REG_DROP_THR, 20'd10000);
                         write_reg(REG_MAX_DELAY, 20'd2000); end
            endcase
            if (phase == 1)
                hold_off = 300;
            for (int n = 0; n < ((phase == 0 || phase == 2) ? 30 : 110); n++)
                random_item();
            now = now + 32'd2000000;
            send(OP_TICK, '0, '0, '0, now, '0);
            wait_idle();
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
